### rtl/core/lssp_pkg.sv
// Package for the least-score server picker: sizes, operation codes, the
// reciprocal constant of the penalty divider and the scan control struct.
// Depends on nothing; every other file of the block but lssp_ram imports it.
`default_nettype none

package lssp_pkg;

  // Table geometry and score format.
  localparam int unsigned MAX_SERVERS = 16;
  localparam int unsigned SCORE_BITS  = 24;
  localparam int unsigned IDX_BITS    = $clog2(MAX_SERVERS);
  localparam int unsigned CNT_BITS    = $clog2(MAX_SERVERS + 1);
  localparam int unsigned SUM_BITS    = SCORE_BITS + IDX_BITS;

  // Fixed widths of the channel fields.
  localparam int unsigned ACTIVE_BITS       = 5;
  localparam int unsigned SERVER_INDEX_BITS = 4;
  localparam int unsigned SCORE_VALUE_BITS  = 24;

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  // Division by ten: q0 = (x * RECIP) >> RECIP_SHIFT is q or q - 1.
  localparam int unsigned RECIP_SHIFT = SUM_BITS + 4;
  localparam int unsigned RECIP_BITS  = SUM_BITS + 1;
  localparam int unsigned PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam int unsigned PEN_BITS    = SUM_BITS - 3;
  localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / 64'd10);

  // Operation codes of an input item.
  typedef enum logic [0:0] {
    OP_WRITE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  // Control of the scan accumulator.
  typedef struct packed {
    logic                start;
    logic                take;
    logic [IDX_BITS-1:0] idx;
  } scan_ctl_t;

endpackage

`default_nettype wire

### rtl/core/lssp_cfg_if.sv
// Configuration write channel of the least-score server picker.
// Depends on lssp_pkg for the register width.
`default_nettype none

interface lssp_cfg_if;
  import lssp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ACTIVE_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/lssp_in_if.sv
// Input item channel of the least-score server picker: score writes and
// server requests. Depends on lssp_pkg for the field widths.
`default_nettype none

interface lssp_in_if;
  import lssp_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [SERVER_INDEX_BITS-1:0] server_index;
  logic [SCORE_VALUE_BITS-1:0]  score_value;

  modport source (output valid, output operation, output server_index,
                  output score_value, input ready);
  modport sink   (input valid, input operation, input server_index,
                  input score_value, output ready);
endinterface

`default_nettype wire

### rtl/core/lssp_out_if.sv
// Result channel of the least-score server picker: one result per request.
// Depends on lssp_pkg for the field widths.
`default_nettype none

interface lssp_out_if;
  import lssp_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [SERVER_INDEX_BITS-1:0] chosen_index;
  logic [SCORE_VALUE_BITS-1:0]  updated_score;

  modport source (output valid, output found, output chosen_index,
                  output updated_score, input ready);
  modport sink   (input valid, input found, input chosen_index,
                  input updated_score, output ready);
endinterface

`default_nettype wire

### rtl/core/lssp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the score table.
`default_nettype none

module lssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/lssp_scan.sv
// Scan accumulator: sums the scores read from the table and tracks the
// lowest one, a later index winning ties. Depends on lssp_pkg.
`default_nettype none

module lssp_scan (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lssp_pkg::scan_ctl_t        ctl_i,
  input  wire logic [lssp_pkg::SCORE_BITS-1:0] score_i,
  output logic [lssp_pkg::SUM_BITS-1:0]   sum_o,
  output logic [lssp_pkg::SCORE_BITS-1:0] best_o,
  output logic [lssp_pkg::IDX_BITS-1:0]   pick_o
);
  import lssp_pkg::*;

  logic                  first_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [SCORE_BITS-1:0] best_q;
  logic [IDX_BITS-1:0]   pick_q;

  // The first flag is control state; it forces the first entry to win.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (ctl_i.start) begin
      first_q <= 1'b1;
    end else if (ctl_i.take) begin
      first_q <= 1'b0;
    end
  end

  // Running sum and minimum; ties go to the entry read last.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sum_q <= '0;
    end else if (ctl_i.take) begin
      sum_q <= sum_q + SUM_BITS'(score_i);
      if (first_q || (score_i <= best_q)) begin
        best_q <= score_i;
        pick_q <= ctl_i.idx;
      end
    end
  end

  assign sum_o  = sum_q;
  assign best_o = best_q;
  assign pick_o = pick_q;

endmodule

`default_nettype wire

### rtl/core/lssp_penalty.sv
// Penalty pipeline: new score = best + (sum - best) / 10, saturated.
// Four stages: difference, reciprocal multiply, correction, saturation.
// Depends on lssp_pkg.
`default_nettype none

module lssp_penalty (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [lssp_pkg::SUM_BITS-1:0]   sum_i,
  input  wire logic [lssp_pkg::SCORE_BITS-1:0] best_i,
  output logic                                 valid_o,
  output logic [lssp_pkg::SCORE_BITS-1:0]      score_o
);
  import lssp_pkg::*;

  logic [3:0]            vld_q;
  logic [SUM_BITS-1:0]   diff1_q, diff2_q;
  logic [SCORE_BITS-1:0] best1_q, best2_q, best3_q;
  logic [PROD_BITS-1:0]  prod_q;
  logic [PEN_BITS-1:0]   pen_q;
  logic [SCORE_BITS-1:0] score_q;

  logic [PEN_BITS-1:0]   quot0;
  logic [SUM_BITS-1:0]   times_ten;
  logic [SUM_BITS-1:0]   remainder;
  logic [SUM_BITS-1:0]   total;

  // Stage valids. A zero sum means every score was zero, so the
  // difference and the penalty come out zero without a special case.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Correction: the reciprocal estimate is low by at most one.
  always_comb begin
    quot0     = prod_q[PROD_BITS-1:RECIP_SHIFT];
    times_ten = SUM_BITS'({quot0, 3'b000}) + SUM_BITS'({quot0, 1'b0});
    remainder = diff2_q - times_ten;
    total     = SUM_BITS'(best3_q) + SUM_BITS'(pen_q);
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      diff1_q <= sum_i - SUM_BITS'(best_i);
      best1_q <= best_i;
    end
    if (vld_q[0]) begin
      prod_q  <= PROD_BITS'(diff1_q) * PROD_BITS'(RECIP);
      diff2_q <= diff1_q;
      best2_q <= best1_q;
    end
    if (vld_q[1]) begin
      pen_q   <= (remainder >= SUM_BITS'(10)) ? quot0 + PEN_BITS'(1) : quot0;
      best3_q <= best2_q;
    end
    if (vld_q[2]) begin
      score_q <= (total > SUM_BITS'(SCORE_MAX)) ? SCORE_MAX
                                                : total[SCORE_BITS-1:0];
    end
  end

  assign valid_o = vld_q[3];
  assign score_o = score_q;

endmodule

`default_nettype wire

### rtl/core/least_score_server_picker_core.sv
// Least-score server picker: top level with the sequencer, the score table
// RAM with its valid bits, and the result register. Depends on lssp_pkg,
// the channel interfaces, lssp_ram, lssp_scan and lssp_penalty.
//
// The block holds a table of MAX_SERVERS scores (unsigned, 8 fraction
// bits) in a RAM with a registered read; per-entry valid bits make an
// unwritten entry read as zero, so there is no clearing pass after reset.
// A score write returns nothing. A request reads the n = min(active_servers,
// MAX_SERVERS) active entries one per cycle through the RAM read port, runs
// a four-stage penalty pipeline and writes the chosen entry back. It holds
// the block until its result enters the output register, which it does only
// once that register is free; with no active server it skips all three steps.
// One item is in work at a time; writes are taken while an earlier result
// still waits in the output register. Configuration is always ready.
`default_nettype none

module least_score_server_picker_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lssp_cfg_if.sink   cfg_i,
  lssp_in_if.sink    item_i,
  lssp_out_if.source result_o
);
  import lssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAUNCH,
    ST_PEN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [ACTIVE_BITS-1:0] active_q;
  logic [MAX_SERVERS-1:0] valid_q;
  logic [CNT_BITS-1:0]    n_q, iss_q;
  logic                   rd_pend_q, rd_last_q, rd_vld_q;
  logic [IDX_BITS-1:0]    rd_idx_q;
  logic                   found_q;

  logic                         out_vld_q;
  logic                         out_found_q;
  logic [SERVER_INDEX_BITS-1:0] out_index_q;
  logic [SCORE_VALUE_BITS-1:0]  out_score_q;

  logic                  in_acc, is_req, idx_ok, out_free, done_xfer;
  logic [CNT_BITS-1:0]   n_now;
  logic                  ram_we, ram_re;
  logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
  logic [SCORE_BITS-1:0] ram_wdata, ram_rdata, scan_score;
  scan_ctl_t             scan_ctl;
  logic [SUM_BITS-1:0]   scan_sum;
  logic [SCORE_BITS-1:0] scan_best;
  logic [IDX_BITS-1:0]   scan_pick;
  logic                  pen_start, pen_vld;
  logic [SCORE_BITS-1:0] pen_score;

  // Handshake decode and the active count, clamped to the table size.
  always_comb begin
    in_acc    = item_i.valid && item_i.ready;
    is_req    = (item_i.operation == OP_REQUEST);
    idx_ok    = (int'(item_i.server_index) < MAX_SERVERS);
    out_free  = !out_vld_q || result_o.ready;
    done_xfer = (state_q == ST_DONE) && out_free;
    if (int'(active_q) > MAX_SERVERS) begin
      n_now = CNT_BITS'(MAX_SERVERS);
    end else begin
      n_now = CNT_BITS'(active_q);
    end
  end

  // Table port selection: writes in idle or at write-back, reads in scan.
  always_comb begin
    ram_re    = (state_q == ST_SCAN) && (iss_q < n_q);
    ram_raddr = iss_q[IDX_BITS-1:0];
    if (state_q == ST_DONE) begin
      ram_we    = done_xfer && found_q;
      ram_waddr = scan_pick;
      ram_wdata = pen_score;
    end else begin
      ram_we    = in_acc && !is_req && idx_ok;
      ram_waddr = IDX_BITS'(item_i.server_index);
      ram_wdata = SCORE_BITS'(item_i.score_value);
    end
    scan_score     = rd_vld_q ? ram_rdata : '0;
    scan_ctl.start = in_acc && is_req;
    scan_ctl.take  = rd_pend_q;
    scan_ctl.idx   = rd_idx_q;
    pen_start      = (state_q == ST_LAUNCH);
  end

  assign cfg_i.ready            = 1'b1;
  assign item_i.ready           = (state_q == ST_IDLE);
  assign result_o.valid         = out_vld_q;
  assign result_o.found         = out_found_q;
  assign result_o.chosen_index  = out_index_q;
  assign result_o.updated_score = out_score_q;

  // Sequencer, valid bits, register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      valid_q     <= '0;
      n_q         <= '0;
      iss_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_index_q <= '0;
      out_score_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        active_q <= cfg_i.data;
      end
      if (done_xfer) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      rd_pend_q <= ram_re;
      if (ram_re) begin
        rd_idx_q  <= ram_raddr;
        rd_vld_q  <= valid_q[ram_raddr];
        rd_last_q <= (iss_q == n_q - CNT_BITS'(1));
        iss_q     <= iss_q + CNT_BITS'(1);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && is_req) begin
            n_q     <= n_now;
            iss_q   <= '0;
            found_q <= (n_now != '0);
            state_q <= (n_now != '0) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (rd_pend_q && rd_last_q) begin
            state_q <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_PEN;
        end
        ST_PEN: begin
          if (pen_vld) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_found_q <= found_q;
            out_index_q <= found_q ? SERVER_INDEX_BITS'(scan_pick) : '0;
            out_score_q <= found_q ? SCORE_VALUE_BITS'(pen_score) : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  lssp_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (MAX_SERVERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lssp_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .score_i (scan_score),
    .sum_o   (scan_sum),
    .best_o  (scan_best),
    .pick_o  (scan_pick)
  );

  lssp_penalty u_penalty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pen_start),
    .sum_i   (scan_sum),
    .best_i  (scan_best),
    .valid_o (pen_vld),
    .score_o (pen_score)
  );

  // The table is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("score table written during scan");

  // Every read returns data that the scan consumes in the next cycle.
  a_read_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> rd_pend_q)
    else $error("table read data not consumed");

  // The read counter never passes the active count.
  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= n_q))
    else $error("scan issued past the active entries");

  // The penalty result only arrives while the sequencer waits for it.
  a_pen_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pen_vld |-> (state_q == ST_PEN))
    else $error("penalty result outside its wait state");

  // A request result is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_vld_q && !result_o.ready) |=>
      (state_q == ST_DONE))
    else $error("result register overwritten");

endmodule

`default_nettype wire

### tb/tb_least_score_server_picker_core.sv
// Testbench for least_score_server_picker_core: score writes and server requests
// with random sender bursts and receiver stalls, checked against a built-in predictor.
// Depends on lssp_pkg, the three lssp channel interfaces and the core RTL.
`default_nettype none

module tb_least_score_server_picker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lssp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned MAX_REPORTS   = 40;

  // Expected outcome of one request.
  typedef struct packed {
    logic                         found;
    logic [SERVER_INDEX_BITS-1:0] idx;
    logic [SCORE_VALUE_BITS-1:0]  score;
  } pick_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_TIGHT
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  lssp_cfg_if cfg_if ();
  lssp_in_if  in_if ();
  lssp_out_if out_if ();

  least_score_server_picker_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (in_if),
    .result_o (out_if)
  );

  // Predictor state: the score table and the active-server register.
  logic [SCORE_BITS-1:0]  score_table [MAX_SERVERS];
  logic [ACTIVE_BITS-1:0] active_servers;
  pick_t                  expected_picks [$];

  int unsigned errors;
  int unsigned writes_sent;
  int unsigned requests_sent;
  int unsigned empty_requests;
  int unsigned saturated_picks;
  int unsigned results_checked;
  int unsigned burst_left;

  sink_mode_e  sink_mode;
  int unsigned sink_phase_left;

  always #10 clk_i = ~clk_i;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_WRITE;
    in_if.server_index = '0;
    in_if.score_value = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      score_table[i] = '0;
    end
    active_servers = '0;
    errors = 0;
    writes_sent = 0;
    requests_sent = 0;
    empty_requests = 0;
    saturated_picks = 0;
    results_checked = 0;
    burst_left = 0;
    sink_mode = SINK_OPEN;
    sink_phase_left = 0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // Scan the active entries, pick the lowest (last on ties), apply the penalty.
  function automatic pick_t serve_request();
    pick_t                 res;
    int unsigned           n;
    logic [31:0]           total;
    logic [31:0]           raised;
    logic [SCORE_BITS-1:0] best;
    logic [IDX_BITS-1:0]   pick;
    n = (active_servers > MAX_SERVERS) ? MAX_SERVERS : active_servers;
    res = '0;
    if (n == 0) begin
      empty_requests++;
      return res;
    end
    total = '0;
    best = '0;
    pick = '0;
    for (int i = 0; i < n; i++) begin
      total += score_table[i];
      if (i == 0 || score_table[i] <= best) begin
        best = score_table[i];
        pick = i[IDX_BITS-1:0];
      end
    end
    raised = (total == 0) ? 32'(best) : 32'(best) + (total - best) / 10;
    if (raised > 32'(SCORE_MAX)) begin
      raised = 32'(SCORE_MAX);
      saturated_picks++;
    end
    score_table[pick] = raised[SCORE_BITS-1:0];
    res.found = 1'b1;
    res.idx = pick;
    res.score = raised[SCORE_BITS-1:0];
    return res;
  endfunction

  // Track accepted configuration writes and input items.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      active_servers = cfg_if.data;
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (op_e'(in_if.operation) == OP_WRITE) begin
        score_table[in_if.server_index] = in_if.score_value;
      end else begin
        expected_picks.push_back(serve_request());
      end
    end
  end

  // Compare every accepted result with the oldest pending request.
  always @(posedge clk_i) begin : check_result
    pick_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = expected_picks.pop_front();
        results_checked++;
        if (out_if.found !== want.found) begin
          report_mismatch($sformatf("found %0b, expected %0b", out_if.found, want.found));
        end
        if (out_if.chosen_index !== want.idx) begin
          report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                    out_if.chosen_index, want.idx));
        end
        if (out_if.updated_score !== want.score) begin
          report_mismatch($sformatf("updated_score 0x%06h, expected 0x%06h",
                                    out_if.updated_score, want.score));
        end
      end
    end
  end

  // Receiver back-pressure: alternate between open, coin-flip and tight phases.
  always @(posedge clk_i) begin
    if (sink_phase_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_phase_left = $urandom_range(16, 96);
    end
    sink_phase_left--;
    case (sink_mode)
      SINK_OPEN: begin
        out_if.ready <= 1'b1;
      end
      SINK_COIN: begin
        out_if.ready <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        out_if.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Send one item; the sender runs in bursts separated by random gaps.
  task automatic send_item(input op_e op, input logic [SERVER_INDEX_BITS-1:0] idx,
                           input logic [SCORE_VALUE_BITS-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.server_index <= idx;
    in_if.score_value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    if (op == OP_WRITE) begin
      writes_sent++;
    end else begin
      requests_sent++;
    end
  endtask

  task automatic write_score(input int unsigned idx, input logic [SCORE_VALUE_BITS-1:0] value);
    send_item(OP_WRITE, idx[SERVER_INDEX_BITS-1:0], value);
  endtask

  // Requests carry random content in the ignored fields.
  task automatic request_server();
    send_item(OP_REQUEST, SERVER_INDEX_BITS'($urandom), SCORE_VALUE_BITS'($urandom));
  endtask

  // Stop sending and let every pending request come back, plus settle time.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Set the active-server count while the block is idle.
  task automatic set_active(input logic [ACTIVE_BITS-1:0] count);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= count;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [SCORE_VALUE_BITS-1:0] random_score();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SCORE_VALUE_BITS'(SCORE_MAX);
      2, 3: return SCORE_VALUE_BITS'($urandom_range(0, 255));
      4: return SCORE_VALUE_BITS'(SCORE_MAX) - SCORE_VALUE_BITS'($urandom_range(0, 255));
      default: return SCORE_VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [ACTIVE_BITS-1:0] random_active();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ACTIVE_BITS'($urandom_range(MAX_SERVERS + 1, 31));
      2, 3: return ACTIVE_BITS'(MAX_SERVERS);
      4: return ACTIVE_BITS'($urandom_range(1, 2));
      default: return ACTIVE_BITS'($urandom_range(1, MAX_SERVERS));
    endcase
  endfunction

  // A request straight after reset sees no active server; then an all-zero table.
  task automatic test_empty_and_zero_table();
    request_server();
    set_active(ACTIVE_BITS'(MAX_SERVERS));
    request_server();
  endtask

  // Saturation on a tie at full scale, and an ordinary penalty.
  task automatic test_score_extremes();
    set_active(ACTIVE_BITS'(2));
    write_score(0, SCORE_VALUE_BITS'(SCORE_MAX));
    write_score(1, SCORE_VALUE_BITS'(SCORE_MAX));
    request_server();
    write_score(0, 24'h000100);
    write_score(1, 24'h000A00);
    request_server();
  endtask

  // An entry written while inactive only counts once the range covers it.
  task automatic test_inactive_entry();
    write_score(9, '0);
    request_server();
    set_active(ACTIVE_BITS'(10));
    request_server();
  endtask

  // Counts above the table size behave as a full table.
  task automatic test_active_clamp();
    set_active(ACTIVE_BITS'(31));
    write_score(MAX_SERVERS - 1, '0);
    request_server();
    set_active(ACTIVE_BITS'(MAX_SERVERS + 1));
    request_server();
    set_active(ACTIVE_BITS'(1));
    request_server();
  endtask

  // Random phases, each with its own active count and write/request mix.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned write_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_active(random_active());
      phase_len = $urandom_range(60, 140);
      write_pct = $urandom_range(30, 70);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(1, 100) <= write_pct) begin
          write_score($urandom_range(0, MAX_SERVERS - 1), random_score());
        end else begin
          request_server();
        end
      end
      sent += phase_len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_zero_table();
    test_score_extremes();
    test_inactive_entry();
    test_active_clamp();
    test_random_traffic();

    wait_drained();
    $display("Covered %0d score writes and %0d requests (%0d with no active server,",
             writes_sent, requests_sent, empty_requests);
    $display("%0d saturated picks); %0d results compared, %0d mismatches.",
             saturated_picks, results_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/lssp_pkg.sv
rtl/core/lssp_cfg_if.sv
rtl/core/lssp_in_if.sv
rtl/core/lssp_out_if.sv
rtl/core/lssp_ram.sv
rtl/core/lssp_scan.sv
rtl/core/lssp_penalty.sv
rtl/core/least_score_server_picker_core.sv
tb/tb_least_score_server_picker_core.sv
